@@ src/rrq_pkg.sv @@
// Package for the round-robin ready queue.
// Holds the request and status codes and the default table depth.
// No dependencies.
package rrq_pkg;

    localparam int MAX_PROCS_DEF = 16;
    localparam int PID_W         = 4;
    localparam int STATUS_W      = 2;
    localparam int LEN_W         = 5;

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_FETCH  = 2'd2
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_QUEUED    = 2'd3
    } t_status;

endpackage

@@ src/rrq_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the link table of the ready queue. No dependencies.
module rrq_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/round_robin_ready_queue_core.sv @@
// Round-robin ready queue of process numbers kept as a linked list.
// Depends on rrq_pkg and on rrq_ram for the link table.
//
//  Channel   Direction  Handshake                Payload
//  request   in         i_in_valid / o_in_stall  i_kind, i_pid
//  result    out        o_out_valid / i_out_stall o_fetched_pid, o_status, o_length
//
// One request is worked at a time; o_in_stall is high from acceptance until the
// result is loaded. Insert, the unused kind, every refused request and a fetch with
// at most one entry queued go straight to S_DONE; other fetches add S_FETCH2, and
// remove adds S_WALK per link ahead of the named process, then S_UNLINK, as the
// link table has a single read port. Reset clears the queue; the link table needs
// no clearing. A stalled result holds and delays the end of the next request.
module round_robin_ready_queue_core
    import rrq_pkg::*;
#(
    parameter int MAX_PROCS = MAX_PROCS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [1:0]          i_kind,
    input  logic [PID_W-1:0]    i_pid,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [PID_W-1:0]    o_fetched_pid,
    output logic [STATUS_W-1:0] o_status,
    output logic [LEN_W-1:0]    o_length
);

    localparam int IW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_EXEC   = 6'b000010,
        S_WALK   = 6'b000100,
        S_UNLINK = 6'b001000,
        S_FETCH2 = 6'b010000,
        S_DONE   = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic [1:0]           r_kind;
    logic [PID_W-1:0]     r_pid;
    logic [MAX_PROCS-1:0] r_queued, n_queued;
    logic [IW-1:0]        r_head, n_head;
    logic [IW-1:0]        r_tail, n_tail;
    logic [LEN_W-1:0]     r_len, n_len;
    logic [IW-1:0]        r_prev, n_prev;
    logic [IW-1:0]        r_cur, n_cur;
    logic                 r_have_prev, n_have_prev;
    logic [PID_W-1:0]     r_res_pid, n_res_pid;
    t_status              r_res_st, n_res_st;
    logic                 r_out_valid;
    logic [PID_W-1:0]     r_out_pid;
    logic [STATUS_W-1:0]  r_out_st;
    logic [LEN_W-1:0]     r_out_len;

    logic          pid_ok;
    logic [IW-1:0] pid_idx;
    logic          pid_queued;
    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    logic [IW-1:0] ram_wdata;
    logic [IW-1:0] ram_raddr;
    logic [IW-1:0] ram_rdata;
    logic          out_load;

    assign pid_ok     = (32'(r_pid) < MAX_PROCS);
    assign pid_idx    = IW'(r_pid);
    assign pid_queued = pid_ok && r_queued[pid_idx];
    assign out_load   = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    rrq_ram #(
        .WIDTH(IW),
        .DEPTH(MAX_PROCS)
    ) u_link_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_queued    = r_queued;
        n_head      = r_head;
        n_tail      = r_tail;
        n_len       = r_len;
        n_prev      = r_prev;
        n_cur       = r_cur;
        n_have_prev = r_have_prev;
        n_res_pid   = r_res_pid;
        n_res_st    = r_res_st;
        ram_we      = 1'b0;
        ram_waddr   = r_tail;
        ram_wdata   = r_head;
        ram_raddr   = r_head;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_res_pid = '0;
                n_res_st  = ST_OK;
                n_state   = S_DONE;
                unique case (r_kind)
                    KIND_INSERT: begin
                        if (!pid_ok) begin
                            n_res_st = ST_NOT_FOUND;
                        end else if (pid_queued) begin
                            n_res_st = ST_QUEUED;
                        end else begin
                            if (r_len == '0) begin
                                n_head = pid_idx;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = r_tail;
                                ram_wdata = pid_idx;
                            end
                            n_tail            = pid_idx;
                            n_queued[pid_idx] = 1'b1;
                            n_len             = r_len + 1'b1;
                        end
                    end
                    KIND_REMOVE: begin
                        if (!pid_queued) begin
                            n_res_st = ST_NOT_FOUND;
                        end else if (r_head == pid_idx) begin
                            n_have_prev = 1'b0;
                            ram_raddr   = pid_idx;
                            n_state     = S_UNLINK;
                        end else begin
                            n_have_prev = 1'b0;
                            n_cur       = r_head;
                            ram_raddr   = r_head;
                            n_state     = S_WALK;
                        end
                    end
                    KIND_FETCH: begin
                        if (r_len == '0) begin
                            n_res_st = ST_EMPTY;
                        end else begin
                            n_res_pid = PID_W'(r_head);
                            if (r_len != LEN_W'(1)) begin
                                ram_raddr = r_head;
                                ram_we    = 1'b1;
                                ram_waddr = r_tail;
                                ram_wdata = r_head;
                                n_tail    = r_head;
                                n_state   = S_FETCH2;
                            end
                        end
                    end
                    default: begin
                        n_res_st = ST_OK;
                    end
                endcase
            end
            S_WALK: begin
                n_prev      = r_cur;
                n_have_prev = 1'b1;
                n_cur       = ram_rdata;
                ram_raddr   = ram_rdata;
                if (ram_rdata == pid_idx) begin
                    n_state = S_UNLINK;
                end
            end
            S_UNLINK: begin
                if (!r_have_prev) begin
                    n_head = ram_rdata;
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = r_prev;
                    ram_wdata = ram_rdata;
                end
                if (r_tail == pid_idx) begin
                    n_tail = r_have_prev ? r_prev : '0;
                end
                n_queued[pid_idx] = 1'b0;
                n_len             = r_len - 1'b1;
                if (r_len == LEN_W'(1)) begin
                    n_head = '0;
                    n_tail = '0;
                end
                n_state = S_DONE;
            end
            S_FETCH2: begin
                n_head  = ram_rdata;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_queued    <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_queued <= n_queued;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_len    <= n_len;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_kind <= i_kind;
            r_pid  <= i_pid;
        end
        r_prev      <= n_prev;
        r_cur       <= n_cur;
        r_have_prev <= n_have_prev;
        r_res_pid   <= n_res_pid;
        r_res_st    <= n_res_st;
        if (out_load) begin
            r_out_pid <= r_res_pid;
            r_out_st  <= r_res_st;
            r_out_len <= r_len;
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_fetched_pid = r_out_pid;
    assign o_status      = r_out_st;
    assign o_length      = r_out_len;

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for round_robin_ready_queue_core: a directed table, then
// random mixes under three sender/receiver idling patterns, results checked against
// table rows or a behavioral queue predictor. Depends on rrq_pkg and the core RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rrq_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int         N_RANDOM    = 450;
    localparam int         N_PLAN      = 25;

    typedef struct packed {
        logic [PID_W-1:0] fetched_pid;
        t_status          status;
        logic [LEN_W-1:0] length;
    } t_result;

    typedef struct packed {
        logic [1:0]       kind;
        logic [PID_W-1:0] pid;
        bit               has_want;
        t_result          want;
    } t_row;

    localparam t_row PLAN [N_PLAN] = '{
        '{KIND_FETCH,  4'd0,  1'b1, '{4'd0, ST_EMPTY,     5'd0}},
        '{KIND_REMOVE, 4'd5,  1'b1, '{4'd0, ST_NOT_FOUND, 5'd0}},
        '{KIND_INSERT, 4'd0,  1'b1, '{4'd0, ST_OK,        5'd1}},
        '{KIND_INSERT, 4'd0,  1'b1, '{4'd0, ST_QUEUED,    5'd1}},
        '{KIND_FETCH,  4'd9,  1'b1, '{4'd0, ST_OK,        5'd1}},
        '{KIND_INSERT, 4'd15, 1'b1, '{4'd0, ST_OK,        5'd2}},
        '{KIND_UNUSED, 4'd15, 1'b1, '{4'd0, ST_OK,        5'd2}},
        '{KIND_FETCH,  4'd0,  1'b1, '{4'd0, ST_OK,        5'd2}},
        '{KIND_FETCH,  4'd15, 1'b0, '0},
        '{KIND_REMOVE, 4'd15, 1'b0, '0},
        '{KIND_REMOVE, 4'd0,  1'b0, '0},
        '{KIND_FETCH,  4'd0,  1'b1, '{4'd0, ST_EMPTY,     5'd0}},
        '{KIND_INSERT, 4'd10, 1'b0, '0},
        '{KIND_INSERT, 4'd5,  1'b0, '0},
        '{KIND_INSERT, 4'd12, 1'b0, '0},
        '{KIND_REMOVE, 4'd5,  1'b0, '0},
        '{KIND_FETCH,  4'd3,  1'b0, '0},
        '{KIND_REMOVE, 4'd10, 1'b0, '0},
        '{KIND_INSERT, 4'd3,  1'b0, '0},
        '{KIND_FETCH,  4'd0,  1'b0, '0},
        '{KIND_REMOVE, 4'd12, 1'b0, '0},
        '{KIND_REMOVE, 4'd3,  1'b0, '0},
        '{KIND_UNUSED, 4'd0,  1'b1, '{4'd0, ST_OK,        5'd0}},
        '{KIND_REMOVE, 4'd15, 1'b1, '{4'd0, ST_NOT_FOUND, 5'd0}},
        '{KIND_INSERT, 4'd15, 1'b0, '0}
    };

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic [1:0]          i_kind      = '0;
    logic [PID_W-1:0]    i_pid       = '0;
    logic                i_out_stall = 1'b0;
    logic                o_in_stall;
    logic                o_out_valid;
    logic [PID_W-1:0]    o_fetched_pid;
    logic [STATUS_W-1:0] o_status;
    logic [LEN_W-1:0]    o_length;

    logic [PID_W-1:0] succ_of [MAX_PROCS_DEF] = '{default: '0};
    bit               in_queue [MAX_PROCS_DEF] = '{default: 1'b0};
    logic [PID_W-1:0] head_pid  = '0;
    logic [PID_W-1:0] tail_pid  = '0;
    logic [LEN_W-1:0] n_queued  = '0;

    t_result pending_results [$];
    int      n_errors    = 0;
    int      tx_idle_pct = 0;
    int      rx_stall_pct = 0;

    round_robin_ready_queue_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_kind        (i_kind),
        .i_pid         (i_pid),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_fetched_pid (o_fetched_pid),
        .o_status      (o_status),
        .o_length      (o_length)
    );

    always #4 i_clk = ~i_clk;

    function automatic t_result predict_request(input logic [1:0] kind,
                                                input logic [PID_W-1:0] pid);
        t_result          res;
        logic [PID_W-1:0] prev;
        logic [PID_W-1:0] cur;
        bit               have_prev;
        res = '{fetched_pid: '0, status: ST_OK, length: '0};
        prev = '0;
        cur = head_pid;
        have_prev = 1'b0;
        case (kind)
            KIND_INSERT: begin
                if (in_queue[pid]) begin
                    res.status = ST_QUEUED;
                end else begin
                    if (n_queued == 0) begin
                        head_pid = pid;
                    end else begin
                        succ_of[tail_pid] = pid;
                    end
                    tail_pid = pid;
                    in_queue[pid] = 1'b1;
                    n_queued++;
                end
            end
            KIND_REMOVE: begin
                if (!in_queue[pid]) begin
                    res.status = ST_NOT_FOUND;
                end else begin
                    for (int i = 0; i < n_queued && cur != pid; i++) begin
                        prev = cur;
                        have_prev = 1'b1;
                        cur = succ_of[cur];
                    end
                    if (cur != pid) begin
                        res.status = ST_NOT_FOUND;
                    end else begin
                        if (!have_prev) begin
                            head_pid = succ_of[pid];
                        end else begin
                            succ_of[prev] = succ_of[pid];
                        end
                        if (tail_pid == pid) begin
                            tail_pid = have_prev ? prev : '0;
                        end
                        in_queue[pid] = 1'b0;
                        n_queued--;
                        if (n_queued == 0) begin
                            head_pid = '0;
                            tail_pid = '0;
                        end
                    end
                end
            end
            KIND_FETCH: begin
                if (n_queued == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.fetched_pid = head_pid;
                    if (n_queued > 1) begin
                        head_pid = succ_of[head_pid];
                        succ_of[tail_pid] = res.fetched_pid;
                        tail_pid = res.fetched_pid;
                    end
                end
            end
            default: ;
        endcase
        res.length = n_queued;
        return res;
    endfunction

    task automatic send_request(input logic [1:0] kind, input logic [PID_W-1:0] pid,
                                input bit has_want, input t_result want);
        t_result predicted;
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_pid      <= pid;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predicted = predict_request(kind, pid);
        pending_results.push_back(has_want ? want : predicted);
    endtask

    task automatic check_result();
        t_result want;
        if (pending_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, got pid %0d status %0d length %0d",
                     $time, o_fetched_pid, o_status, o_length);
            n_errors++;
        end else begin
            want = pending_results.pop_front();
            if (o_fetched_pid !== want.fetched_pid) begin
                $display("%0t: fetched_pid expected %0d, got %0d",
                         $time, want.fetched_pid, o_fetched_pid);
                n_errors++;
            end
            if (o_status !== want.status) begin
                $display("%0t: status expected %0d, got %0d", $time, want.status, o_status);
                n_errors++;
            end
            if (o_length !== want.length) begin
                $display("%0t: length expected %0d, got %0d", $time, want.length, o_length);
                n_errors++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            check_result();
        end
        i_out_stall <= ($urandom_range(99) < rx_stall_pct);
    end

    initial begin
        #5_000_000;
        $display("round_robin_ready_queue_core: mismatch");
        $finish;
    end

    initial begin
        logic [1:0]       kind;
        logic [PID_W-1:0] pid;
        int               insert_pct;
        int               roll;
        int               pick;
        insert_pct = 45;
        tx_idle_pct = 9;
        rx_stall_pct = 77;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < N_PLAN; r++) begin
            send_request(PLAN[r].kind, PLAN[r].pid, PLAN[r].has_want, PLAN[r].want);
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM / 3) begin
                tx_idle_pct = 77;
                rx_stall_pct = 9;
            end else if (n == 2 * N_RANDOM / 3) begin
                tx_idle_pct = 0;
                rx_stall_pct = 0;
            end
            if (n % 50 == 0) begin
                insert_pct = 25 + 20 * $urandom_range(2);
            end
            roll = $urandom_range(99);
            pid = PID_W'($urandom_range(MAX_PROCS_DEF - 1));
            if (roll < 4) begin
                kind = KIND_UNUSED;
            end else if (roll < 4 + insert_pct) begin
                kind = KIND_INSERT;
            end else if (roll < 4 + insert_pct + (96 - insert_pct) / 2) begin
                kind = KIND_REMOVE;
                if (n_queued != 0 && $urandom_range(99) < 80) begin
                    pick = $urandom_range(n_queued - 1);
                    for (int p = 0; p < MAX_PROCS_DEF; p++) begin
                        if (in_queue[p]) begin
                            if (pick == 0) pid = PID_W'(p);
                            pick--;
                        end
                    end
                end
            end else begin
                kind = KIND_FETCH;
            end
            send_request(kind, pid, 1'b0, '0);
        end
        i_in_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (MAX_PROCS_DEF + 8) @(posedge i_clk);
        if (n_errors == 0 && pending_results.size() == 0) begin
            $display("round_robin_ready_queue_core: match");
        end else begin
            $display("round_robin_ready_queue_core: mismatch");
        end
        $finish;
    end
endmodule
